/* rtl/rag_pkg.sv */
// Shared types and constants for the rational arithmetic block.
// No dependencies; compile first.
package rag_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int REQ_TYPE_W        = 2;
    localparam int RES_NUM_W         = 32;
    localparam int RES_DEN_W         = 30;

    localparam logic [REQ_TYPE_W-1:0] OP_ADD = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] OP_SUB = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] OP_MUL = 2'd2;
    localparam logic [REQ_TYPE_W-1:0] OP_DIV = 2'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } rag_stat_t;

endpackage

/* rtl/rag_in_if.sv */
// Request channel: operation and two fractions, valid/ready handshake.
// Depends on rag_pkg.
interface rag_in_if #(parameter int OPERAND_WIDTH = 16);
    import rag_pkg::*;

    logic                             valid;
    logic                             ready;
    logic [REQ_TYPE_W-1:0]            req_type;
    logic signed [OPERAND_WIDTH-1:0]  a_num;
    logic [OPERAND_WIDTH-2:0]         a_den;
    logic signed [OPERAND_WIDTH-1:0]  b_num;
    logic [OPERAND_WIDTH-2:0]         b_den;

    modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

/* rtl/rag_out_if.sv */
// Result channel: reduced fraction and compare flags, valid/ready handshake.
// Depends on rag_pkg.
interface rag_out_if;
    import rag_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [RES_NUM_W-1:0] res_num;
    logic [RES_DEN_W-1:0]        res_den;
    logic                        is_greater;
    logic                        is_less;
    logic                        is_equal;
    logic                        div_by_zero;

    modport source (output valid, res_num, res_den, is_greater, is_less, is_equal,
                    div_by_zero, input ready);
    modport sink   (input valid, res_num, res_den, is_greater, is_less, is_equal,
                    div_by_zero, output ready);
endinterface

/* rtl/rag_mul.sv */
// Shared signed multiplier with a registered product.
// No package dependencies.
module rag_mul #(
    parameter int OP_W = 17
) (
    input  logic                     clk,
    input  logic signed [OP_W-1:0]   op_a,
    input  logic signed [OP_W-1:0]   op_b,
    output logic signed [2*OP_W-1:0] prod
);

    logic signed [2*OP_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

/* rtl/rag_gcd.sv */
// Binary greatest common divisor, one shift or subtract per cycle.
// Depends on rag_pkg for the status struct.
module rag_gcd #(
    parameter int MAG_W = 31
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MAG_W-1:0]  x_in,
    input  logic [MAG_W-1:0]  y_in,
    output logic [MAG_W-1:0]  g,
    output rag_pkg::rag_stat_t stat
);
    import rag_pkg::*;

    localparam int KW = $clog2(MAG_W + 1);

    logic [MAG_W-1:0] x_reg, x_next;
    logic [MAG_W-1:0] y_reg, y_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [MAG_W-1:0] g_reg, g_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        k_next    = k_reg;
        g_next    = g_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = x_in;
            y_next    = y_in;
            k_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (x_reg == '0)
            begin
                g_next    = MAG_W'(y_reg << k_reg);
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (!x_reg[0] && !y_reg[0])
            begin
                x_next = x_reg >> 1;
                y_next = y_reg >> 1;
                k_next = k_reg + KW'(1);
            end
            else if (!x_reg[0])
            begin
                x_next = x_reg >> 1;
            end
            else if (!y_reg[0])
            begin
                y_next = y_reg >> 1;
            end
            else if (x_reg >= y_reg)
            begin
                x_next = x_reg - y_reg;
            end
            else
            begin
                y_next = y_reg - x_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        k_reg <= k_next;
        g_reg <= g_next;
    end

    assign g         = g_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    a_y_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> y_reg != '0)
        else $error("gcd operand y reached zero");

    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> done_reg)
        else $error("gcd stopped without done");

    a_g_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> g_reg != '0)
        else $error("gcd result is zero");

endmodule

/* rtl/rag_div.sv */
// Two-lane restoring divider sharing one divisor, one quotient bit per cycle.
// Depends on rag_pkg for the status struct.
module rag_div #(
    parameter int MAG_W = 31
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MAG_W-1:0]  dvd_a,
    input  logic [MAG_W-1:0]  dvd_b,
    input  logic [MAG_W-1:0]  dvs,
    output logic [MAG_W-1:0]  quo_a,
    output logic [MAG_W-1:0]  quo_b,
    output rag_pkg::rag_stat_t stat
);
    import rag_pkg::*;

    localparam int CW = $clog2(MAG_W + 1);

    logic [MAG_W-1:0] qa_reg, qa_next;
    logic [MAG_W-1:0] qb_reg, qb_next;
    logic [MAG_W-1:0] ra_reg, ra_next;
    logic [MAG_W-1:0] rb_reg, rb_next;
    logic [MAG_W-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [MAG_W:0]   sha, shb;
    logic             ge_a, ge_b;

    always_comb
    begin
        sha  = {ra_reg, qa_reg[MAG_W-1]};
        shb  = {rb_reg, qb_reg[MAG_W-1]};
        ge_a = sha >= {1'b0, dvs_reg};
        ge_b = shb >= {1'b0, dvs_reg};
    end

    always_comb
    begin
        qa_next   = qa_reg;
        qb_next   = qb_reg;
        ra_next   = ra_reg;
        rb_next   = rb_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            qa_next   = dvd_a;
            qb_next   = dvd_b;
            ra_next   = '0;
            rb_next   = '0;
            dvs_next  = dvs;
            cnt_next  = CW'(MAG_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            ra_next  = ge_a ? MAG_W'(sha - {1'b0, dvs_reg}) : MAG_W'(sha);
            rb_next  = ge_b ? MAG_W'(shb - {1'b0, dvs_reg}) : MAG_W'(shb);
            qa_next  = {qa_reg[MAG_W-2:0], ge_a};
            qb_next  = {qb_reg[MAG_W-2:0], ge_b};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qa_reg  <= qa_next;
        qb_reg  <= qb_next;
        ra_reg  <= ra_next;
        rb_reg  <= rb_next;
        dvs_reg <= dvs_next;
    end

    assign quo_a     = qa_reg;
    assign quo_b     = qb_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    a_exact: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ra_reg == '0 && rb_reg == '0)
        else $error("reduction left a remainder");

    a_dvs_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> dvs_reg != '0)
        else $error("divide by zero divisor");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");

endmodule

/* rtl/rational_arith_gcd_reduce.sv */
// Top level: fraction add/sub/mul/div with gcd reduction and compare flags.
// Depends on rag_pkg, rag_in_if, rag_out_if, rag_mul, rag_gcd, rag_div.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   req_type, a_num, a_den, b_num, b_den
//   rsp      out  valid/ready   res_num, res_den, is_greater, is_less, is_equal, div_by_zero
//
// One request passes through the states in order: S_MUL forms four products through the shared
// multiplier, S_SETUP sets up the reduction, S_GCD runs the gcd with its control steps, S_DIV
// divides numerator and denominator by the gcd, S_OUT loads the output, and the block returns to
// S_IDLE. The binary gcd does one shift or subtract per cycle. req.ready is high only while idle.
// Reset is asynchronous, active low, and clears all control state. A stalled rsp holds the next
// result in the output state.
module rational_arith_gcd_reduce #(
    parameter int OPERAND_WIDTH = rag_pkg::OPERAND_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    rag_in_if.sink    req,
    rag_out_if.source rsp
);
    import rag_pkg::*;

    localparam int DW = OPERAND_WIDTH - 1;
    localparam int PW = 2 * OPERAND_WIDTH;
    localparam int MW = PW - 1;
    localparam int FW = OPERAND_WIDTH + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_GCD   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]                      state_reg, state_next;
    logic [2:0]                      mcnt_reg, mcnt_next;
    logic [REQ_TYPE_W-1:0]           op_reg;
    logic signed [OPERAND_WIDTH-1:0] an_reg, bn_reg;
    logic [DW-1:0]                   ad_reg, bd_reg;
    logic signed [PW-1:0]            lhs_reg, rhs_reg, nn_reg;
    logic [MW-1:0]                   dd_reg;
    logic [MW-1:0]                   mag_reg, den_reg;
    logic                            neg_reg, gt_reg, lt_reg, eq_reg, dz_reg;
    logic                            ov_reg, ov_next;
    logic signed [RES_NUM_W-1:0]     res_num_reg;
    logic [RES_DEN_W-1:0]            res_den_reg;
    logic                            rgt_reg, rlt_reg, req_reg, rdz_reg;

    logic signed [FW-1:0]            mul_a, mul_b;
    logic signed [2*FW-1:0]          prod;
    logic signed [PW-1:0]            prod_t;
    logic signed [PW-1:0]            t_s;
    logic [MW-1:0]                   mag_s, den_s;
    logic                            neg_s, dz_s;
    logic signed [PW-1:0]            sres;
    logic [MW-1:0]                   g;
    logic [MW-1:0]                   quo_num, quo_den;
    rag_stat_t                       gcd_stat, div_stat;
    logic                            accept, gcd_start, div_start, load_out;

    assign accept    = req.valid && req.ready;
    assign gcd_start = state_reg == S_SETUP;
    assign div_start = state_reg == S_GCD && gcd_stat.done;
    assign load_out  = state_reg == S_OUT && (!ov_reg || rsp.ready);
    assign prod_t    = PW'(prod);

    always_comb
    begin
        case (mcnt_reg)
            3'd0:
            begin
                mul_a = FW'(an_reg);
                mul_b = $signed({1'b0, 1'b0, bd_reg});
            end
            3'd1:
            begin
                mul_a = $signed({1'b0, 1'b0, ad_reg});
                mul_b = FW'(bn_reg);
            end
            3'd2:
            begin
                mul_a = FW'(an_reg);
                mul_b = FW'(bn_reg);
            end
            3'd3:
            begin
                mul_a = $signed({1'b0, 1'b0, ad_reg});
                mul_b = $signed({1'b0, 1'b0, bd_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    rag_mul #(.OP_W(FW)) u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    always_comb
    begin
        t_s   = nn_reg;
        den_s = dd_reg;
        dz_s  = 1'b0;
        neg_s = 1'b0;
        case (op_reg)
            OP_ADD:  t_s = lhs_reg + rhs_reg;
            OP_SUB:  t_s = lhs_reg - rhs_reg;
            OP_MUL:  t_s = nn_reg;
            OP_DIV:
            begin
                t_s   = lhs_reg;
                den_s = MW'(rhs_reg[PW-1] ? -rhs_reg : rhs_reg);
                neg_s = rhs_reg[PW-1];
            end
            default: t_s = nn_reg;
        endcase
        neg_s = neg_s ^ t_s[PW-1];
        mag_s = MW'(t_s[PW-1] ? -t_s : t_s);
        if (op_reg == OP_DIV && bn_reg == '0)
        begin
            dz_s  = 1'b1;
            neg_s = 1'b0;
            mag_s = '0;
            den_s = MW'(1);
        end
    end

    rag_gcd #(.MAG_W(MW)) u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .x_in  (mag_s),
        .y_in  (den_s),
        .g     (g),
        .stat  (gcd_stat)
    );

    rag_div #(.MAG_W(MW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .dvd_a (mag_reg),
        .dvd_b (den_reg),
        .dvs   (g),
        .quo_a (quo_num),
        .quo_b (quo_den),
        .stat  (div_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        mcnt_next  = mcnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MUL;
                    mcnt_next  = '0;
                end
            end
            S_MUL:
            begin
                mcnt_next = mcnt_reg + 3'd1;
                if (mcnt_reg == 3'd4)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP: state_next = S_GCD;
            S_GCD:
            begin
                if (gcd_stat.done)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (load_out)
        begin
            ov_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mcnt_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mcnt_reg  <= mcnt_next;
            ov_reg    <= ov_next;
        end
    end

    assign sres = neg_reg ? -$signed({1'b0, quo_num}) : $signed({1'b0, quo_num});

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= req.req_type;
            an_reg <= req.a_num;
            bn_reg <= req.b_num;
            ad_reg <= (req.a_den == '0) ? DW'(1) : req.a_den;
            bd_reg <= (req.b_den == '0) ? DW'(1) : req.b_den;
        end
        if (state_reg == S_MUL)
        begin
            case (mcnt_reg)
                3'd1:    lhs_reg <= prod_t;
                3'd2:    rhs_reg <= prod_t;
                3'd3:    nn_reg  <= prod_t;
                3'd4:    dd_reg  <= MW'(prod_t);
                default: ;
            endcase
        end
        if (state_reg == S_SETUP)
        begin
            mag_reg <= mag_s;
            den_reg <= den_s;
            neg_reg <= neg_s;
            dz_reg  <= dz_s;
            gt_reg  <= lhs_reg > rhs_reg;
            lt_reg  <= lhs_reg < rhs_reg;
            eq_reg  <= lhs_reg == rhs_reg;
        end
        if (load_out)
        begin
            res_num_reg <= RES_NUM_W'(sres);
            res_den_reg <= RES_DEN_W'(quo_den);
            rgt_reg     <= gt_reg;
            rlt_reg     <= lt_reg;
            req_reg     <= eq_reg;
            rdz_reg     <= dz_reg;
        end
    end

    assign req.ready       = state_reg == S_IDLE;
    assign rsp.valid       = ov_reg;
    assign rsp.res_num     = res_num_reg;
    assign rsp.res_den     = res_den_reg;
    assign rsp.is_greater  = rgt_reg;
    assign rsp.is_less     = rlt_reg;
    assign rsp.is_equal    = req_reg;
    assign rsp.div_by_zero = rdz_reg;

    a_dz_src: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && dz_reg) |-> (op_reg == OP_DIV && bn_reg == '0))
        else $error("div_by_zero without a zero divisor");

    a_out_units_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT |-> !gcd_stat.busy && !div_stat.busy)
        else $error("result taken while a unit is busy");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !gcd_stat.busy && !div_stat.busy && !gcd_stat.done && !div_stat.done)
        else $error("request accepted while a unit is active");

endmodule
